FILE: sv/pl0_pkg.sv
package pl0_pkg;

  typedef enum logic [4:0] {
    OP_NEG   = 5'd0,
    OP_ODD   = 5'd1,
    OP_ADD   = 5'd2,
    OP_SUB   = 5'd3,
    OP_MUL   = 5'd4,
    OP_DIV   = 5'd5,
    OP_EQU   = 5'd6,
    OP_NEQ   = 5'd7,
    OP_LT    = 5'd8,
    OP_GTE   = 5'd9,
    OP_GT    = 5'd10,
    OP_LTE   = 5'd11,
    OP_PUSHC = 5'd12,
    OP_PUSHV = 5'd13,
    OP_POP   = 5'd14,
    OP_CALL  = 5'd15,
    OP_RET   = 5'd16,
    OP_ENTER = 5'd17,
    OP_JUMP  = 5'd18,
    OP_JNEQ  = 5'd19
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BADOP = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_BOUND = 2'd3
  } status_e;

  localparam int unsigned ReqTypeWidth  = 5;
  localparam int unsigned LevelWidth    = 4;
  localparam int unsigned OperandWidth  = 32;
  localparam int unsigned OutPcWidth    = 16;
  localparam int unsigned OutAddrWidth  = 10;
  localparam int unsigned OutValueWidth = 32;

  typedef struct packed {
    logic start;
    logic is_signed;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: sv/pl0_div.sv
module pl0_div #(
  parameter int unsigned Width = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pl0_pkg::div_ctl_t    ctl_i,
  input  logic [Width-1:0]     dividend_i,
  input  logic [Width-1:0]     divisor_i,
  output pl0_pkg::div_sts_t    sts_o,
  output logic [Width-1:0]     quotient_o
);
  import pl0_pkg::*;

  localparam int unsigned CntWidth = $clog2(Width + 1);

  logic [Width-1:0]    rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic                neg_q, neg_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [Width:0]      trial;
  logic [Width-1:0]    ua, ub;

  always_comb begin
    ua = (ctl_i.is_signed && dividend_i[Width-1]) ? (~dividend_i + 1'b1) : dividend_i;
    ub = (ctl_i.is_signed && divisor_i[Width-1]) ? (~divisor_i + 1'b1) : divisor_i;
    trial = {rem_q, quo_q[Width-1]} - {1'b0, dvs_q};
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      rem_d = '0;
      quo_d = ua;
      dvs_d = ub;
      neg_d = ctl_i.is_signed && (dividend_i[Width-1] ^ divisor_i[Width-1]);
      cnt_d = CntWidth'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Width-2:0], quo_q[Width-1]};
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

FILE: sv/pl0_stack_machine_core.sv
// PL/0 p-code execution core.
// Input channel: one instruction per request (req_type_i, level_i, operand_i),
// accepted when in_valid_i is high and in_stall_o is low.
// Output channel: one result per instruction (next pc, halted, status and the
// variable write of a pop), taken when out_valid_o is high and out_stall_i low.
// The core handles one instruction at a time: it decodes the instruction, walks
// the static chain for push variable, pop and call, reads its stack operands,
// executes it (a divide runs the shift-subtract divider), writes the stack as
// needed and registers the result. The stack memory reads one word per cycle.
// The next request can be accepted in the cycle after the result is registered.
// The result sits in an output register; the next request is accepted while it
// waits, but it is not finished until the result has been taken, so a stalled
// receiver holds the core after at most one further request.
// Reset clears pc and frame base, sets the stack top to -1 (empty stack) and
// clears the first three stack words through three valid flags; no clearing pass is needed.
module pl0_stack_machine_core #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned WORD_WIDTH  = 32,
  parameter int unsigned PC_WIDTH    = 16,
  parameter int unsigned MAX_LEVEL   = 15
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pl0_pkg::ReqTypeWidth-1:0]     req_type_i,
  input  logic [pl0_pkg::LevelWidth-1:0]       level_i,
  input  logic signed [pl0_pkg::OperandWidth-1:0] operand_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [pl0_pkg::OutPcWidth-1:0]       next_pc_o,
  output logic                                 halted_o,
  output logic [1:0]                           status_o,
  output logic                                 write_valid_o,
  output logic [pl0_pkg::OutAddrWidth-1:0]     write_addr_o,
  output logic signed [pl0_pkg::OutValueWidth-1:0] write_value_o
);
  import pl0_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned SW = AW + 2;
  localparam int unsigned CW = (WORD_WIDTH > SW) ? WORD_WIDTH + 2 : SW + 2;
  localparam logic signed [SW-1:0] Depth = SW'(STACK_DEPTH);
  localparam logic signed [CW-1:0] DepthC = CW'(STACK_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_CHAIN = 10'b0000000100,
    S_RD1   = 10'b0000001000,
    S_RD2   = 10'b0000010000,
    S_EXEC  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_WR    = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Stack memory with registered read.
  logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr, rd_addr_q;
  logic [WORD_WIDTH-1:0] mem_wdata, mem_rdata, rdata_q;
  logic [2:0]            low_vld_q, low_vld_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
    rd_addr_q <= mem_raddr;
  end

  always_comb begin
    mem_rdata = rdata_q;
    if (rd_addr_q == AW'(0) && !low_vld_q[0]) mem_rdata = '0;
    if (rd_addr_q == AW'(1) && !low_vld_q[1]) mem_rdata = '0;
    if (rd_addr_q == AW'(2) && !low_vld_q[2]) mem_rdata = '0;
  end

  // Architectural and working registers.
  logic [PC_WIDTH-1:0]     pc_q, pc_d;
  logic [AW-1:0]           bp_q, bp_d;
  logic signed [SW-1:0]    sp_q, sp_d;
  logic [4:0]              op_q, op_d;
  logic [LevelWidth-1:0]   lvl_q, lvl_d;
  logic [OperandWidth-1:0] opnd_q, opnd_d;
  logic [AW-1:0]           b_q, b_d;
  logic [WORD_WIDTH-1:0]   x_q, x_d, y_q, y_d, r_q, r_d;
  logic [1:0]              wcnt_q, wcnt_d;
  logic                    pend_q, pend_d;
  logic [1:0]              st_q, st_d;

  logic                    ov_q, ov_d;
  logic [OutPcWidth-1:0]   o_pc_q, o_pc_d;
  logic                    o_halt_q, o_halt_d;
  logic [1:0]              o_st_q, o_st_d;
  logic                    o_wv_q, o_wv_d;
  logic [OutAddrWidth-1:0] o_wa_q, o_wa_d;
  logic [OutValueWidth-1:0] o_wd_q, o_wd_d;

  div_ctl_t              div_ctl;
  div_sts_t              div_sts;
  logic [WORD_WIDTH-1:0] div_q;

  pl0_div #(.Width(WORD_WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (x_q),
    .divisor_i  (y_q),
    .sts_o      (div_sts),
    .quotient_o (div_q)
  );

  logic                    accept, out_take;
  logic [PC_WIDTH-1:0]     npc;
  logic signed [CW-1:0]    opnd_s, sp_w, bp_w, b_w, tmp, nsp;
  logic [WORD_WIDTH-1:0]   wopnd;
  logic [PC_WIDTH-1:0]     tgt_pc;
  logic signed [WORD_WIDTH-1:0] xs, ys;
  logic [AW-1:0]           var_addr;
  logic                    var_ok;

  assign out_take = ov_q && !out_stall_i;
  assign in_stall_o = pend_q;
  assign accept = in_valid_i && !pend_q;

  always_comb begin
    npc = pc_q + 1'b1;
    opnd_s = CW'($signed(opnd_q));
    sp_w = CW'(sp_q);
    bp_w = CW'({1'b0, bp_q});
    b_w = CW'({1'b0, b_q});
    wopnd = WORD_WIDTH'($signed(opnd_q));
    tgt_pc = PC_WIDTH'(opnd_q);
    xs = $signed(x_q);
    ys = $signed(y_q);
    tmp = b_w + opnd_s;
    var_ok = (tmp >= 0) && (tmp < DepthC);
    var_addr = AW'(tmp);
  end

  function automatic logic addr_ok(input logic signed [CW-1:0] a);
    return (a >= 0) && (a < DepthC);
  endfunction

  function automatic logic link_ok(input logic [WORD_WIDTH-1:0] w);
    return {{CW-WORD_WIDTH{1'b0}}, w} < CW'(STACK_DEPTH);
  endfunction

  always_comb begin
    state_d = state_q;
    pc_d = pc_q; bp_d = bp_q; sp_d = sp_q;
    op_d = op_q; lvl_d = lvl_q; opnd_d = opnd_q;
    b_d = b_q; x_d = x_q; y_d = y_q; r_d = r_q;
    wcnt_d = wcnt_q; st_d = st_q;
    pend_d = pend_q;
    low_vld_d = low_vld_q;
    ov_d = ov_q;
    o_pc_d = o_pc_q; o_halt_d = o_halt_q; o_st_d = o_st_q;
    o_wv_d = o_wv_q; o_wa_d = o_wa_q; o_wd_d = o_wd_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
    nsp = '0;
    div_ctl.start = 1'b0;
    div_ctl.is_signed = 1'b1;

    if (out_take) ov_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = req_type_i;
          lvl_d = level_i;
          opnd_d = operand_i;
          b_d = bp_q;
          st_d = ST_OK;
          pend_d = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_DONE;
        if (op_q > OP_JNEQ) begin
          st_d = ST_BADOP;
        end else if (op_q == OP_PUSHV || op_q == OP_POP || op_q == OP_CALL) begin
          if (32'(lvl_q) > 32'(MAX_LEVEL)) st_d = ST_BOUND;
          else if (lvl_q != '0) begin
            mem_raddr = b_q;
            state_d = S_CHAIN;
          end else state_d = S_RD1;
        end else if (op_q == OP_PUSHC) begin
          if (!addr_ok(sp_w + 1)) st_d = ST_BOUND;
          else state_d = S_EXEC;
        end else if (op_q == OP_ENTER) begin
          nsp = sp_w + opnd_s;
          if (nsp < -1 || nsp >= DepthC) st_d = ST_BOUND;
          else begin
            sp_d = SW'(nsp);
            pc_d = npc;
          end
        end else if (op_q == OP_JUMP) begin
          pc_d = tgt_pc;
        end else if (op_q == OP_RET) begin
          nsp = bp_w - 1 - opnd_s;
          if (!addr_ok(bp_w + 2) || nsp < -1 || nsp >= DepthC) st_d = ST_BOUND;
          else begin
            mem_raddr = AW'(bp_w + 1);
            state_d = S_RD1;
          end
        end else if (op_q <= OP_LTE) begin
          if (!addr_ok(sp_w)) st_d = ST_BOUND;
          else if (op_q >= OP_ADD && sp_q < 1) st_d = ST_BOUND;
          else begin
            mem_raddr = AW'(sp_w);
            state_d = S_RD1;
          end
        end else begin
          if (!addr_ok(sp_w)) st_d = ST_BOUND;
          else begin
            mem_raddr = AW'(sp_w);
            state_d = S_RD1;
          end
        end
      end
      S_CHAIN: begin
        if (!link_ok(mem_rdata)) begin
          st_d = ST_BOUND;
          state_d = S_DONE;
        end else begin
          b_d = AW'(mem_rdata);
          lvl_d = lvl_q - 1'b1;
          if (lvl_q == LevelWidth'(1)) state_d = S_RD1;
          else mem_raddr = AW'(mem_rdata);
        end
      end
      S_RD1: begin
        state_d = S_RD2;
        if (op_q == OP_RET) begin
          if (!link_ok(mem_rdata)) begin
            st_d = ST_BOUND;
            state_d = S_DONE;
          end else begin
            x_d = mem_rdata;
            mem_raddr = AW'(bp_w + 2);
          end
        end else if (op_q == OP_PUSHV) begin
          if (!var_ok || !addr_ok(sp_w + 1)) begin
            st_d = ST_BOUND;
            state_d = S_DONE;
          end else mem_raddr = var_addr;
        end else if (op_q == OP_POP) begin
          if (!var_ok || !addr_ok(sp_w)) begin
            st_d = ST_BOUND;
            state_d = S_DONE;
          end else mem_raddr = AW'(sp_w);
        end else if (op_q == OP_CALL) begin
          if (sp_w + 3 >= DepthC) begin
            st_d = ST_BOUND;
            state_d = S_DONE;
          end else begin
            wcnt_d = 2'd0;
            state_d = S_WR;
          end
        end else begin
          y_d = mem_rdata;
          if (op_q inside {[OP_ADD:OP_LTE]}) mem_raddr = AW'(sp_w - 1);
        end
      end
      S_RD2: begin
        state_d = S_EXEC;
        if (op_q == OP_RET) begin
          pc_d = PC_WIDTH'(mem_rdata);
          bp_d = AW'(x_q);
          sp_d = SW'(bp_w - 1 - opnd_s);
          state_d = S_DONE;
        end else if (op_q == OP_PUSHV || op_q == OP_POP) begin
          y_d = mem_rdata;
        end else if (op_q inside {[OP_ADD:OP_LTE]}) begin
          x_d = mem_rdata;
        end
      end
      S_EXEC: begin
        state_d = S_WR;
        wcnt_d = 2'd2;
        pc_d = npc;
        case (op_q)
          OP_NEG: r_d = '0 - y_q;
          OP_ODD: r_d = WORD_WIDTH'(y_q[0]);
          OP_ADD: r_d = x_q + y_q;
          OP_SUB: r_d = x_q - y_q;
          OP_MUL: r_d = x_q * y_q;
          OP_DIV: begin
            if (y_q == '0) begin
              r_d = '0;
              st_d = ST_DIVZ;
            end else begin
              div_ctl.start = 1'b1;
              state_d = S_DIV;
            end
          end
          OP_EQU: r_d = WORD_WIDTH'(x_q == y_q);
          OP_NEQ: r_d = WORD_WIDTH'(x_q != y_q);
          OP_LT:  r_d = WORD_WIDTH'(xs < ys);
          OP_GTE: r_d = WORD_WIDTH'(!(xs < ys));
          OP_GT:  r_d = WORD_WIDTH'(ys < xs);
          OP_LTE: r_d = WORD_WIDTH'(!(ys < xs));
          OP_PUSHC: r_d = wopnd;
          OP_PUSHV, OP_POP: r_d = y_q;
          OP_JNEQ: begin
            pc_d = (y_q == '0) ? tgt_pc : npc;
            sp_d = sp_q - 1'b1;
            state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DIV: begin
        if (div_sts.done) begin
          r_d = div_q;
          state_d = S_WR;
        end
      end
      S_WR: begin
        mem_we = 1'b1;
        state_d = S_DONE;
        if (op_q == OP_CALL) begin
          mem_waddr = AW'(sp_w + 1 + CW'(wcnt_q));
          case (wcnt_q)
            2'd0: mem_wdata = WORD_WIDTH'(b_q);
            2'd1: mem_wdata = WORD_WIDTH'(bp_q);
            default: mem_wdata = WORD_WIDTH'(npc);
          endcase
          if (wcnt_q != 2'd2) begin
            wcnt_d = wcnt_q + 1'b1;
            state_d = S_WR;
          end else begin
            bp_d = AW'(sp_w + 1);
            pc_d = tgt_pc;
          end
        end else begin
          mem_wdata = r_q;
          if (op_q == OP_NEG || op_q == OP_ODD) mem_waddr = AW'(sp_w);
          else if (op_q == OP_PUSHC || op_q == OP_PUSHV) begin
            mem_waddr = AW'(sp_w + 1);
            sp_d = sp_q + 1'b1;
          end else if (op_q == OP_POP) begin
            mem_waddr = var_addr;
            sp_d = sp_q - 1'b1;
          end else begin
            mem_waddr = AW'(sp_w - 1);
            sp_d = sp_q - 1'b1;
          end
        end
        if (mem_waddr == AW'(0)) low_vld_d[0] = 1'b1;
        if (mem_waddr == AW'(1)) low_vld_d[1] = 1'b1;
        if (mem_waddr == AW'(2)) low_vld_d[2] = 1'b1;
      end
      S_DONE: begin
        if (!ov_q || out_take) begin
          ov_d = 1'b1;
          o_pc_d = OutPcWidth'(pc_q);
          o_halt_d = (pc_q == '0);
          o_st_d = st_q;
          o_wv_d = (op_q == OP_POP) && (st_q == ST_OK);
          o_wa_d = o_wv_d ? OutAddrWidth'(var_addr) : '0;
          o_wd_d = o_wv_d ? OutValueWidth'(r_q) : '0;
          pend_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0;
      bp_q <= '0;
      sp_q <= '1;
      pend_q <= 1'b0;
      ov_q <= 1'b0;
      low_vld_q <= '0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      bp_q <= bp_d;
      sp_q <= sp_d;
      pend_q <= pend_d;
      ov_q <= ov_d;
      low_vld_q <= low_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; lvl_q <= lvl_d; opnd_q <= opnd_d;
    b_q <= b_d; x_q <= x_d; y_q <= y_d; r_q <= r_d;
    wcnt_q <= wcnt_d; st_q <= st_d;
    o_pc_q <= o_pc_d; o_halt_q <= o_halt_d; o_st_q <= o_st_d;
    o_wv_q <= o_wv_d; o_wa_q <= o_wa_d; o_wd_q <= o_wd_d;
  end

  assign out_valid_o   = ov_q;
  assign next_pc_o     = o_pc_q;
  assign halted_o      = o_halt_q;
  assign status_o      = o_st_q;
  assign write_valid_o = o_wv_q;
  assign write_addr_o  = o_wa_q;
  assign write_value_o = o_wd_q;

`ifndef SYNTHESIS
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q) else $error("pending flag set while idle");
  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (halted_o == (next_pc_o == '0))) else $error("halted mismatch");
  a_wv_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_valid_o) |-> (status_o == ST_OK)) else $error("write on fault");
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q >= -1) && (sp_q < Depth)) else $error("stack top out of range");
`endif

endmodule
